@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/frc_pkg.sv @@
package frc_pkg;

   localparam int unsigned HDR_LEN       = 14;
   localparam int unsigned HDR_IDX_W     = $clog2(HDR_LEN);
   localparam int unsigned LENGTH_LIMIT  = 524288;
   localparam int unsigned CNT_W         = 20;   // width of max_payload
   localparam int unsigned QDEPTH        = 4;
   localparam int unsigned QPTR_W        = $clog2(QDEPTH);

   localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES      = 32'hFFFFFFFF;

   localparam logic [31:0]      MAGIC_RESET       = 32'h5447564E;
   localparam logic [15:0]      VERSION_RESET     = 16'd1;
   localparam logic [CNT_W-1:0] MAX_PAYLOAD_RESET = CNT_W'(524288);

   typedef enum logic [1:0] {
      CSR_MAGIC       = 2'd0,
      CSR_VERSION     = 2'd1,
      CSR_MAX_PAYLOAD = 2'd2
   } frc_csr_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_MAGIC    = 3'd1,
      ST_BAD_VERSION  = 3'd2,
      ST_TOO_LONG     = 3'd3,
      ST_CRC_MISMATCH = 3'd4
   } frc_status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_REPORT  = 1'b1
   } frc_kind_type;

   typedef enum logic {
      PH_HEADER  = 1'b0,
      PH_PAYLOAD = 1'b1
   } frc_phase_type;

   typedef struct packed {
      logic [31:0]      magic;
      logic [15:0]      version;
      logic [CNT_W-1:0] max_payload;
   } frc_cfg_type;

   // One queued unit of work for the back end.
   typedef struct packed {
      frc_kind_type   kind;
      logic [7:0]     data;
      logic           last;
      frc_status_type status;
      logic [31:0]    crc_exp;
   } frc_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } frc_qstat_type;

   // Reflected CRC-32, one byte.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/frc_front.sv @@
module frc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  frc_pkg::frc_cfg_type  cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  frc_pkg::frc_qstat_type qstat,
   output logic                  push,
   output frc_pkg::frc_entry_type push_entry
);
   import frc_pkg::*;

   frc_phase_type          phase_ff, phase_in;
   logic [HDR_IDX_W-1:0]   hdr_idx_ff;
   logic [7:0]             hdr_ff [HDR_LEN];
   logic [CNT_W-1:0]       left_ff;

   logic                   accept;
   logic                   hdr_last;
   logic                   pay_last;
   logic [31:0]            magic, hlen, hcrc, limit;
   logic [15:0]            version;
   logic                   hdr_report;
   logic                   hdr_start;
   frc_status_type         hdr_status;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign hdr_last  = (hdr_idx_ff == HDR_IDX_W'(HDR_LEN - 1));
   assign pay_last  = (left_ff[CNT_W-1:1] == '0);

   // last header byte arrives on the port, the rest comes from the store
   assign magic   = {hdr_ff[3], hdr_ff[2], hdr_ff[1], hdr_ff[0]};
   assign version = {hdr_ff[5], hdr_ff[4]};
   assign hlen    = {hdr_ff[9], hdr_ff[8], hdr_ff[7], hdr_ff[6]};
   assign hcrc    = {req_rx_byte, hdr_ff[12], hdr_ff[11], hdr_ff[10]};
   assign limit   = (32'(cfg.max_payload) < 32'(LENGTH_LIMIT)) ?
                    32'(cfg.max_payload) : 32'(LENGTH_LIMIT);

   always_comb begin
      hdr_report = 1'b1;
      hdr_start  = 1'b0;
      hdr_status = ST_OK;
      priority if (magic != cfg.magic) begin
         hdr_status = ST_BAD_MAGIC;
      end else if (version != cfg.version) begin
         hdr_status = ST_BAD_VERSION;
      end else if (hlen > limit) begin
         hdr_status = ST_TOO_LONG;
      end else if (hlen == 32'd0) begin
         hdr_status = (hcrc == 32'd0) ? ST_OK : ST_CRC_MISMATCH;
      end else begin
         hdr_report = 1'b0;
         hdr_start  = 1'b1;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (accept && hdr_last && hdr_start) phase_in = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (accept && pay_last) phase_in = PH_HEADER;
         end
         default: phase_in = PH_HEADER;
      endcase
   end

   // queue push
   always_comb begin
      push               = 1'b0;
      push_entry.kind    = KIND_PAYLOAD;
      push_entry.data    = req_rx_byte;
      push_entry.last    = 1'b0;
      push_entry.status  = hdr_status;
      push_entry.crc_exp = {hdr_ff[13], hdr_ff[12], hdr_ff[11], hdr_ff[10]};
      unique case (phase_ff)
         PH_HEADER: begin
            push            = accept && hdr_last && hdr_report;
            push_entry.kind = KIND_REPORT;
            push_entry.data = 8'd0;
            push_entry.last = 1'b1;
         end
         PH_PAYLOAD: begin
            push            = accept;
            push_entry.last = pay_last;
         end
         default: push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= '0;
         left_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         if (accept && phase_ff == PH_HEADER) begin
            hdr_idx_ff <= hdr_last ? '0 : hdr_idx_ff + 1'b1;
            if (hdr_last && hdr_start) left_ff <= hlen[CNT_W-1:0];
         end
         if (accept && phase_ff == PH_PAYLOAD && left_ff != '0) begin
            left_ff <= left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_HEADER) hdr_ff[hdr_idx_ff] <= req_rx_byte;
   end

endmodule

@@ hw/rtl/frc_queue.sv @@
module frc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  frc_pkg::frc_entry_type push_entry,
   input  logic                   pop,
   output frc_pkg::frc_entry_type pop_entry,
   output frc_pkg::frc_qstat_type qstat
);
   import frc_pkg::*;

   frc_entry_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign pop_entry       = mem_ff[rd_ptr_ff];
   assign qstat.full      = (count_ff == (QPTR_W + 1)'(QDEPTH));
   assign qstat.not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

@@ hw/rtl/frc_back.sv @@
module frc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  frc_pkg::frc_qstat_type qstat,
   input  frc_pkg::frc_entry_type entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_has_byte,
   output logic                   rsp_frame_end,
   output logic [2:0]             rsp_frame_status
);
   import frc_pkg::*;

   logic [31:0]    crc_ff, crc_in;
   logic           rsp_valid_ff;
   logic [7:0]     byte_ff;
   logic           has_ff, end_ff;
   frc_status_type status_ff;

   logic           load;
   logic [31:0]    crc_next;
   frc_status_type crc_status;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign pop        = qstat.not_empty && load;
   assign crc_next   = crc32_byte(crc_ff, entry.data);
   assign crc_status = ((crc_next ^ CRC_ONES) == entry.crc_exp) ? ST_OK : ST_CRC_MISMATCH;

   always_comb begin
      crc_in = crc_ff;
      if (pop && entry.kind == KIND_PAYLOAD) begin
         crc_in = entry.last ? CRC_ONES : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         if (load) rsp_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff <= entry.data;
         end_ff  <= entry.last;
         if (entry.kind == KIND_PAYLOAD) begin
            has_ff    <= 1'b1;
            status_ff <= entry.last ? crc_status : ST_OK;
         end else begin
            has_ff    <= 1'b0;
            status_ff <= entry.status;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_has_byte     = has_ff;
   assign rsp_frame_end    = end_ff;
   assign rsp_frame_status = status_ff;

endmodule

@@ hw/rtl/frame_receive_check_crc32_top.sv @@
// Byte-serial receiver for length-prefixed frames guarded by CRC-32. Each
// input transaction carries one link byte. The first 14 bytes of a frame form
// a little-endian header (magic, version, payload length, payload CRC); after
// the last header byte the magic, version and length limit are checked in that
// order, and a failure gives one result transaction with no byte, frame_end set
// and the error status, after which header collection restarts with the next
// byte. A zero-length frame ends at its header with status ok or crc mismatch.
// Each payload byte comes out as one result transaction; the last one also
// carries frame_end and the CRC verdict. Header bytes of a good frame produce
// no result. Throughput is one byte per clock: the front end takes a byte each
// cycle unless its 4-entry work queue is full, and the back end runs the
// byte-wide CRC update combinationally and loads the output register. An
// accepted byte passes through the queue and then the output register. A full
// queue, which only builds up while the result side stalls, stalls the input.
// Configuration (csr_index 0 magic, 1 version, 2 max payload) is to be written
// by the user only while the block is idle, which the block does not enforce;
// the effective length limit is the smaller of max payload and 524288.
`include "assert_macros.svh"

module frame_receive_check_crc32_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_has_byte,
   output logic        rsp_frame_end,
   output logic [2:0]  rsp_frame_status,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import frc_pkg::*;

   // config registers
   frc_cfg_type   cfg_ff;

   // front -> queue -> back
   logic          push;
   logic          pop;
   frc_entry_type push_entry;
   frc_entry_type pop_entry;
   frc_qstat_type qstat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic       <= MAGIC_RESET;
         cfg_ff.version     <= VERSION_RESET;
         cfg_ff.max_payload <= MAX_PAYLOAD_RESET;
      end else if (csr_we) begin
         unique case (frc_csr_type'(csr_index))
            CSR_MAGIC:       cfg_ff.magic       <= csr_wdata;
            CSR_VERSION:     cfg_ff.version     <= csr_wdata[15:0];
            CSR_MAX_PAYLOAD: cfg_ff.max_payload <= csr_wdata[CNT_W-1:0];
            default:         cfg_ff             <= cfg_ff;  // unmapped index
         endcase
      end
   end

   // header capture, checks and payload counting
   frc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   // short decoupling queue
   frc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .pop_entry (pop_entry),
      .qstat     (qstat)
   );

   // running CRC and result register
   frc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .entry           (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_frame_status(rsp_frame_status)
   );

   // queue must never be written when full or read when empty
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !qstat.full, "queue overflow")
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, qstat.not_empty, "queue underflow")
   // a result without a byte is always a frame-level report
   `ASSERT_IMPLIES(a_report_ends, clock, reset, rsp_valid && !rsp_has_byte,
                   rsp_frame_end && rsp_payload_byte == 8'd0, "report without frame end")
   // a stalled result stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_frame_status) && $stable(rsp_payload_byte),
                "stalled result changed")

endmodule
